>>> rtl/core/boee_pkg.sv
// Package for the binary offset-escape encoder: shared constants and types.
// Used by the front, the queue, the back and the top level.
package boee_pkg;

  localparam int MAX_LEN_DEF = 32;
  localparam int LEN_W       = 6;
  localparam int CNT_W       = 6;
  localparam int HIST_DEPTH  = 256;

  localparam logic [7:0] QUOTE_CODE = 8'd39;
  localparam logic [7:0] ESC_BYTE   = 8'd1;
  localparam logic [7:0] LAST_CAND  = 8'hff;

  localparam logic [1:0] SEL_NONE  = 2'd0;
  localparam logic [1:0] SEL_ZERO  = 2'd1;
  localparam logic [1:0] SEL_ONE   = 2'd2;
  localparam logic [1:0] SEL_QUOTE = 2'd3;

  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_PAIR = 2'd2;

  typedef struct packed {
    logic [7:0]       offset;
    logic [LEN_W-1:0] len;
    logic             ovf;
  } job_t;

  typedef struct packed {
    logic             we;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

endpackage

>>> rtl/core/boee_in_if.sv
// Input channel of the encoder: one message byte and its last-byte mark per word.
// Stands alone; the handshake is valid and ready.
interface boee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/core/boee_out_if.sv
// Result channel of the encoder: one offset or code word per handshake.
// Stands alone; the handshake is valid and ready.
interface boee_out_if;
  logic       valid;
  logic       ready;
  logic       is_offset;
  logic [7:0] first_code;
  logic [1:0] second_code;
  logic [1:0] code_count;
  logic       run_end;
  logic       overflow;

  modport source (output valid, output is_offset, output first_code, output second_code,
                  output code_count, output run_end, output overflow, input ready);
  modport sink   (input valid, input is_offset, input first_code, input second_code,
                  input code_count, input run_end, input overflow, output ready);
endinterface

>>> rtl/core/binary_offset_escape_encoder_unit.sv
// Binary offset-escape encoder. A stored byte passes the load and increment states,
// a dropped byte only the load state. After the last byte the histogram is scanned,
// one candidate per cycle on the two-port histogram memory; the job then enters the queue.
// The back emits the offset, then one word per stored byte, one per cycle while out_ch is ready.
// Synchronous active-low reset clears all control state and the histogram valid bits at once;
// there is no clearing pass.
module binary_offset_escape_encoder_unit #(
  parameter int MAX_LEN = boee_pkg::MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  boee_in_if.sink    in_ch,
  boee_out_if.source out_ch
);
  import boee_pkg::*;

  job_t      fq_data;
  logic      fq_valid;
  logic      fq_ready;
  job_t      qb_data;
  logic      qb_valid;
  logic      qb_ready;
  store_wr_t st_wr;
  logic      msg_done;

  boee_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job_data  (fq_data),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .st_wr     (st_wr),
    .msg_done  (msg_done)
  );

  boee_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (fq_data),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .pop_data   (qb_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready)
  );

  boee_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .st_wr     (st_wr),
    .job_data  (qb_data),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .msg_done  (msg_done),
    .out_ch    (out_ch)
  );

  // The offset word is always a single code and never ends a message.
  a_offset_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_offset |-> out_ch.code_count == CNT_ONE && !out_ch.run_end)
    else $error("offset word malformed");

  // An escape pair always starts with the escape byte and carries a selector.
  a_escape_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.code_count == CNT_PAIR |->
      out_ch.first_code == ESC_BYTE && out_ch.second_code != SEL_NONE)
    else $error("escape pair malformed");

  // A single data code never carries a value that must be escaped.
  a_single_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.code_count == CNT_ONE && !out_ch.is_offset |->
      out_ch.first_code != 8'd0 && out_ch.first_code != ESC_BYTE &&
      out_ch.first_code != QUOTE_CODE)
    else $error("unescaped data code");

  // New bytes are taken only once the previous message has left the store.
  a_store_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !qb_valid && !fq_valid)
    else $error("input open while a job is pending");

endmodule

>>> rtl/core/boee_front.sv
// Front of the encoder: accepts bytes, builds the value histogram and scans it for the offset.
// Depends on boee_pkg and boee_in_if; hands jobs to the queue and store writes to the back.
module boee_front #(
  parameter int MAX_LEN = boee_pkg::MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  boee_in_if.sink             in_ch,
  output boee_pkg::job_t      job_data,
  output logic                job_valid,
  input  logic                job_ready,
  output boee_pkg::store_wr_t st_wr,
  input  logic                msg_done
);
  import boee_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD, ST_INC, ST_PRE, ST_SCAN, ST_PUSH, ST_HOLD
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             drop_r, drop_nxt;
  logic             last_r, last_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [7:0]       iss_r, iss_nxt;
  logic [7:0]       best_r, best_nxt;
  logic [7:0]       off_r, off_nxt;
  logic [7:0]       evv_r, evv_nxt;
  logic             evvld_r, evvld_nxt;
  logic [CNT_W-1:0] cur_r, cur_nxt;

  logic [CNT_W-1:0] hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_vld_r;
  logic [CNT_W-1:0] ca_r, cb_r;
  logic [7:0]       addr_a, addr_b;

  logic             acc;
  logic             room;
  logic [7:0]       score;
  logic             win;

  assign acc   = in_ch.valid && in_ch.ready;
  assign room  = len_r < LEN_W'(MAX_LEN);
  assign score = {2'b00, cur_r} + {2'b00, ca_r} + {2'b00, cb_r};
  assign win   = (evv_r != QUOTE_CODE) && (score < best_r);

  assign in_ch.ready = (state_r == ST_LOAD);
  assign job_valid   = (state_r == ST_PUSH);
  assign job_data    = '{offset: off_r, len: len_r, ovf: drop_r};

  assign st_wr.we   = acc && room;
  assign st_wr.addr = len_r;
  assign st_wr.data = in_ch.data_byte;

  always_comb begin
    case (state_r)
      ST_LOAD: addr_a = in_ch.data_byte;
      ST_PRE:  addr_a = 8'd1;
      default: addr_a = iss_r + 8'd1;
    endcase
    addr_b = iss_r + QUOTE_CODE;
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    drop_nxt  = drop_r;
    last_nxt  = last_r;
    byte_nxt  = byte_r;
    iss_nxt   = iss_r;
    best_nxt  = best_r;
    off_nxt   = off_r;
    evv_nxt   = evv_r;
    evvld_nxt = 1'b0;
    cur_nxt   = cur_r;
    case (state_r)
      ST_LOAD: begin
        if (acc) begin
          byte_nxt = in_ch.data_byte;
          last_nxt = in_ch.last_byte;
          if (room) begin
            state_nxt = ST_INC;
          end else begin
            drop_nxt = 1'b1;
            if (in_ch.last_byte) begin
              state_nxt = ST_PRE;
            end
          end
        end
      end
      ST_INC: begin
        len_nxt   = len_r + LEN_W'(1);
        state_nxt = last_r ? ST_PRE : ST_LOAD;
      end
      ST_PRE: begin
        iss_nxt   = 8'd1;
        best_nxt  = {{(8-LEN_W){1'b0}}, len_r};
        off_nxt   = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        iss_nxt   = iss_r + 8'd1;
        cur_nxt   = ca_r;
        evv_nxt   = iss_r;
        evvld_nxt = 1'b1;
        if (evvld_r) begin
          if (win) begin
            best_nxt = score;
            off_nxt  = evv_r;
          end
          if ((evv_r == LAST_CAND) || (win && (score == 8'd0))) begin
            evvld_nxt = 1'b0;
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (job_ready) begin
          len_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (msg_done) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      len_r   <= '0;
      drop_r  <= 1'b0;
      last_r  <= 1'b0;
      byte_r  <= '0;
      iss_r   <= '0;
      best_r  <= '0;
      off_r   <= '0;
      evv_r   <= '0;
      evvld_r <= 1'b0;
      cur_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      drop_r  <= drop_nxt;
      last_r  <= last_nxt;
      byte_r  <= byte_nxt;
      iss_r   <= iss_nxt;
      best_r  <= best_nxt;
      off_r   <= off_nxt;
      evv_r   <= evv_nxt;
      evvld_r <= evvld_nxt;
      cur_r   <= cur_nxt;
    end
  end

  // An entry without its valid bit reads as zero, so clearing the valid bits clears the histogram.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (state_r == ST_PUSH && job_ready) begin
      hist_vld_r <= '0;
    end else if (state_r == ST_INC) begin
      hist_vld_r[byte_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_INC) begin
      hist_mem[byte_r] <= ca_r + CNT_W'(1);
    end
    ca_r <= hist_vld_r[addr_a] ? hist_mem[addr_a] : '0;
    cb_r <= hist_vld_r[addr_b] ? hist_mem[addr_b] : '0;
  end

endmodule

>>> rtl/core/boee_queue.sv
// Two-entry job queue between the front and the back of the encoder.
// Depends on boee_pkg for the job type.
module boee_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  boee_pkg::job_t push_data,
  input  logic           push_valid,
  output logic           push_ready,
  output boee_pkg::job_t pop_data,
  output logic           pop_valid,
  input  logic           pop_ready
);
  import boee_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/core/boee_back.sv
// Back of the encoder: holds the message store and emits the offset and the escaped code words.
// Depends on boee_pkg and boee_out_if; takes jobs from the queue.
module boee_back #(
  parameter int MAX_LEN = boee_pkg::MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  boee_pkg::store_wr_t st_wr,
  input  boee_pkg::job_t      job_data,
  input  logic                job_valid,
  output logic                job_ready,
  output logic                msg_done,
  boee_out_if.source          out_ch
);
  import boee_pkg::*;

  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  typedef enum logic {
    ST_IDLE, ST_BYTE
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       off_r, off_nxt;
  logic             ovf_r, ovf_nxt;
  logic             ov_r, ov_nxt;
  logic             iso_r, iso_nxt;
  logic [7:0]       fc_r, fc_nxt;
  logic [1:0]       sc_r, sc_nxt;
  logic [1:0]       cc_r, cc_nxt;
  logic             end_r, end_nxt;

  logic [7:0]       store_mem [MAX_LEN];
  logic [7:0]       rd_data_r;
  logic [LEN_W-1:0] rd_addr;
  logic [LEN_W-1:0] idx_inc;
  logic             free;
  logic             at_last;
  logic [7:0]       diff;

  assign free    = !ov_r || out_ch.ready;
  assign idx_inc = idx_r + LEN_W'(1);
  assign at_last = (idx_inc == len_r);
  assign diff    = rd_data_r - off_r;

  assign job_ready = (state_r == ST_IDLE) && free;
  assign msg_done  = (state_r == ST_BYTE) && free && at_last;

  assign out_ch.valid       = ov_r;
  assign out_ch.is_offset   = iso_r;
  assign out_ch.first_code  = fc_r;
  assign out_ch.second_code = sc_r;
  assign out_ch.code_count  = cc_r;
  assign out_ch.run_end     = end_r;
  assign out_ch.overflow    = ovf_r;

  always_comb begin
    case (state_r)
      ST_IDLE: rd_addr = '0;
      default: rd_addr = free ? idx_inc : idx_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    off_nxt   = off_r;
    ovf_nxt   = ovf_r;
    ov_nxt    = ov_r && !out_ch.ready;
    iso_nxt   = iso_r;
    fc_nxt    = fc_r;
    sc_nxt    = sc_r;
    cc_nxt    = cc_r;
    end_nxt   = end_r;
    case (state_r)
      ST_IDLE: begin
        if (job_valid && free) begin
          len_nxt   = job_data.len;
          off_nxt   = job_data.offset;
          ovf_nxt   = job_data.ovf;
          idx_nxt   = '0;
          ov_nxt    = 1'b1;
          iso_nxt   = 1'b1;
          fc_nxt    = job_data.offset;
          sc_nxt    = SEL_NONE;
          cc_nxt    = CNT_ONE;
          end_nxt   = (job_data.len == '0);
          state_nxt = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (free) begin
          ov_nxt  = 1'b1;
          iso_nxt = 1'b0;
          end_nxt = at_last;
          fc_nxt  = ESC_BYTE;
          cc_nxt  = CNT_PAIR;
          case (diff)
            8'd0:       sc_nxt = SEL_ZERO;
            8'd1:       sc_nxt = SEL_ONE;
            QUOTE_CODE: sc_nxt = SEL_QUOTE;
            default: begin
              fc_nxt = diff;
              sc_nxt = SEL_NONE;
              cc_nxt = CNT_ONE;
            end
          endcase
          if (at_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      len_r   <= '0;
      off_r   <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
      iso_r   <= 1'b0;
      fc_r    <= '0;
      sc_r    <= '0;
      cc_r    <= '0;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      off_r   <= off_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
      iso_r   <= iso_nxt;
      fc_r    <= fc_nxt;
      sc_r    <= sc_nxt;
      cc_r    <= cc_nxt;
      end_r   <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_wr.we) begin
      store_mem[st_wr.addr[ADDR_W-1:0]] <= st_wr.data;
    end
    rd_data_r <= store_mem[rd_addr[ADDR_W-1:0]];
  end

endmodule
